// ===== rtl/core/leb_pkg.sv =====
// shared types and constants for the line edit buffer
`timescale 1ns / 1ps

package leb_pkg;

   // buffer depth default
   localparam int LINE_DEPTH_DEFAULT = 64;

   // register reset values
   localparam logic [7:0] ERASE_CHAR_RESET    = 8'd35;  // '#'
   localparam logic [7:0] KILL_CHAR_RESET     = 8'd64;  // '@'
   localparam logic [7:0] LINE_END_CHAR_RESET = 8'd10;  // line feed

   // register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_ERASE_CHAR    = 2'd0,
      CSR_KILL_CHAR     = 2'd1,
      CSR_LINE_END_CHAR = 2'd2
   } csr_index_type;

   // item opcodes
   localparam logic OP_CHAR  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // what an incoming character means
   typedef enum logic [1:0] {
      CLS_PLAIN,
      CLS_LINE_END,
      CLS_ERASE,
      CLS_KILL
   } char_class_type;

   // controller to datapath
   typedef struct packed {
      logic push;        // store char at fill position
      logic erase;       // drop newest char if any
      logic kill;        // empty line, clear overflow flag
      logic set_ovf;     // char lost to a full buffer
      logic load;        // move fetched char into output register
      logic clear_line;  // end of release: reset fill, flag, read pointer
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      char_class_type cls;
      logic           fill_empty;
      logic           fill_full;
      logic           rd_last;
      logic           out_free;
   } stat_type;

endpackage

// ===== rtl/core/leb_req_if.sv =====
// request channel: one character or flush item
`timescale 1ns / 1ps

interface leb_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] char_in;

   modport source (output valid, output op, output char_in, input ready);
   modport sink   (input valid, input op, input char_in, output ready);
endinterface

// ===== rtl/core/leb_rsp_if.sv =====
// response channel: one released character
`timescale 1ns / 1ps

interface leb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       last_of_line;
   logic       chars_dropped;

   modport source (output valid, output char_out, output last_of_line,
                   output chars_dropped, input ready);
   modport sink   (input valid, input char_out, input last_of_line,
                   input chars_dropped, output ready);
endinterface

// ===== rtl/core/line_edit_buffer.sv =====
// top level of the line edit buffer
`timescale 1ns / 1ps

// Line edit buffer: characters arrive on req_ch and collect in a LINE_DEPTH
// entry line memory. The erase character drops the newest buffered char (no
// effect when empty), the kill character empties the line and clears the
// overflow flag, and the line-end character or a flush item (op = 1) releases
// the line on rsp_ch oldest first, one item per character, last_of_line on the
// final one. If the line is empty a release sends nothing. A plain char that
// finds the memory full is lost and chars_dropped is set on every char of that
// line. When one code matches several registers, line end wins over erase and
// erase over kill. A char, erase, kill or empty release leaves req_ch.ready
// high, so the next item is accepted the cycle after. A release holds
// req_ch.ready low while the drain loop moves one char per cycle, unless
// rsp_ch stalls, from the memory's registered read port to the output
// register. csr_* writes take effect at the next edge and belong in idle
// periods only; indexes beyond 2 are ignored.
module line_edit_buffer #(
   parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   leb_req_if.sink    req_ch,
   leb_rsp_if.source  rsp_ch,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   leb_pkg::cmd_type  cmd;    // controller commands to the datapath
   leb_pkg::stat_type stat;   // char class, fill and drain status

   // sequencing: accept, classify, drain
   leb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // line memory, fill count, overflow flag, registers, output stage
   leb_datapath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_char    (req_ch.char_in),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_char    (rsp_ch.char_out),
      .rsp_last    (rsp_ch.last_of_line),
      .rsp_dropped (rsp_ch.chars_dropped),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// ===== rtl/core/leb_ctrl.sv =====
// controller state machine for the line edit buffer
`timescale 1ns / 1ps

module leb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_op,
   output logic              req_ready,
   input  leb_pkg::stat_type stat,
   output leb_pkg::cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      req_fire;
   logic      is_release;

   assign req_ready  = ready_ff;
   assign req_fire   = req_valid && ready_ff;
   assign is_release = (req_op == leb_pkg::OP_FLUSH) ||
                       (stat.cls == leb_pkg::CLS_LINE_END);

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            ready_in = 1'b1;
            if (req_fire) begin
               if (is_release) begin
                  if (stat.fill_empty) begin
                     cmd.clear_line = 1'b1;
                  end else begin
                     state_in = ST_DRAIN;
                     ready_in = 1'b0;
                  end
               end else begin
                  case (stat.cls)
                     leb_pkg::CLS_ERASE: cmd.erase = 1'b1;
                     leb_pkg::CLS_KILL:  cmd.kill  = 1'b1;
                     default: begin
                        if (stat.fill_full) cmd.set_ovf = 1'b1;
                        else                cmd.push    = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_DRAIN: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               if (stat.rd_last) begin
                  cmd.clear_line = 1'b1;
                  state_in       = ST_IDLE;
                  ready_in       = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule

// ===== rtl/core/leb_datapath.sv =====
// line memory, counters, config registers and output register
`timescale 1ns / 1ps

module leb_datapath #(
   parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   input  logic [7:0]        req_char,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [7:0]        rsp_char,
   output logic              rsp_last,
   output logic              rsp_dropped,
   input  leb_pkg::cmd_type  cmd,
   output leb_pkg::stat_type stat
);

   localparam int IdxW = $clog2(LINE_DEPTH);
   localparam int CntW = $clog2(LINE_DEPTH + 1);

   logic [7:0] line_mem [LINE_DEPTH];

   logic [7:0]      erase_char_ff, kill_char_ff, line_end_char_ff;
   logic [CntW-1:0] fill_ff, fill_in;
   logic            ovf_ff, ovf_in;
   logic [IdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0]      rd_data_ff;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_char_ff;
   logic            out_last_ff;
   logic            out_dropped_ff;
   logic            rd_last;

   assign rd_last = (CntW'(rd_ptr_ff) + CntW'(1)) == fill_ff;

   // status to the controller
   // classify the incoming character, line end first, then erase, then kill
   always_comb begin
      if (req_char == line_end_char_ff)   stat.cls = leb_pkg::CLS_LINE_END;
      else if (req_char == erase_char_ff) stat.cls = leb_pkg::CLS_ERASE;
      else if (req_char == kill_char_ff)  stat.cls = leb_pkg::CLS_KILL;
      else                                stat.cls = leb_pkg::CLS_PLAIN;
      stat.fill_empty = (fill_ff == '0);
      stat.fill_full  = (fill_ff == CntW'(LINE_DEPTH));
      stat.rd_last    = rd_last;
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      rd_ptr_in    = rd_ptr_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      if (cmd.push)                        fill_in = fill_ff + CntW'(1);
      if (cmd.erase && !stat.fill_empty)   fill_in = fill_ff - CntW'(1);
      if (cmd.kill) begin
         fill_in = '0;
         ovf_in  = 1'b0;
      end
      if (cmd.set_ovf)                     ovf_in = 1'b1;
      if (cmd.load) begin
         out_valid_in = 1'b1;
         rd_ptr_in    = rd_ptr_ff + IdxW'(1);
      end
      if (cmd.clear_line) begin
         fill_in   = '0;
         ovf_in    = 1'b0;
         rd_ptr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         erase_char_ff    <= leb_pkg::ERASE_CHAR_RESET;
         kill_char_ff     <= leb_pkg::KILL_CHAR_RESET;
         line_end_char_ff <= leb_pkg::LINE_END_CHAR_RESET;
         fill_ff          <= '0;
         ovf_ff           <= 1'b0;
         rd_ptr_ff        <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               leb_pkg::CSR_ERASE_CHAR:    erase_char_ff    <= csr_wdata;
               leb_pkg::CSR_KILL_CHAR:     kill_char_ff     <= csr_wdata;
               leb_pkg::CSR_LINE_END_CHAR: line_end_char_ff <= csr_wdata;
               default: ;
            endcase
         end
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rd_ptr_ff    <= rd_ptr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // memory: one write port, registered read at the next read pointer
   always_ff @(posedge clock) begin
      if (cmd.push) line_mem[fill_ff[IdxW-1:0]] <= req_char;
      rd_data_ff <= line_mem[rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_char_ff    <= rd_data_ff;
         out_last_ff    <= rd_last;
         out_dropped_ff <= ovf_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_char    = out_char_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_dropped = out_dropped_ff;

endmodule

// ===== rtl/core/leb_checker.sv =====
// port-level checks for the line edit buffer, bound to the top level
`timescale 1ns / 1ps

module leb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_char,
   input logic       rsp_last,
   input logic       rsp_dropped
);

   // a stalled item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char) &&
                                  $stable(rsp_last) && $stable(rsp_dropped))
      else $error("rsp item changed while stalled");

   // input stays closed while a line is still draining
   a_no_accept_mid_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input open during line release");

   // drain keeps up: next char follows a taken non-final char at once
   a_drain_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a released line");

   // the dropped flag is the same on every char of a line
   a_dropped_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_dropped == $past(rsp_dropped))
      else $error("chars_dropped changed within a line");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_char    (rsp_ch.char_out),
   .rsp_last    (rsp_ch.last_of_line),
   .rsp_dropped (rsp_ch.chars_dropped)
);

// ===== dv/leb_line_checker.sv =====
// checker: predicts released lines from observed items and compares them
`timescale 1ns / 1ps

module leb_line_checker #(
   parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   leb_req_if         req_ch,
   leb_rsp_if         rsp_ch,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   output int         mismatch_count,
   output int         pending_chars
);

   typedef struct packed {
      logic [7:0] char_out;
      logic       last_of_line;
      logic       chars_dropped;
   } line_char_type;

   line_char_type released_line_q[$];

   logic [7:0] line_q[$];
   logic       overflow_flag;
   logic [7:0] erase_code;
   logic [7:0] kill_code;
   logic [7:0] line_end_code;

   task automatic release_line();
      line_char_type c;
      int            n;
      n = line_q.size();
      for (int k = 0; k < n; k++) begin
         c.char_out      = line_q[k];
         c.last_of_line  = (k == n - 1);
         c.chars_dropped = overflow_flag;
         released_line_q.push_back(c);
      end
      line_q.delete();
      overflow_flag = 1'b0;
   endtask

   // line end beats erase, erase beats kill
   task automatic edit_line(input logic op, input logic [7:0] ch);
      if (op == leb_pkg::OP_FLUSH || ch == line_end_code) begin
         release_line();
      end else if (ch == erase_code) begin
         if (line_q.size() > 0) void'(line_q.pop_back());
      end else if (ch == kill_code) begin
         line_q.delete();
         overflow_flag = 1'b0;
      end else if (line_q.size() >= LINE_DEPTH) begin
         overflow_flag = 1'b1;
      end else begin
         line_q.push_back(ch);
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      line_char_type want;
      if (reset) begin
         erase_code     = leb_pkg::ERASE_CHAR_RESET;
         kill_code      = leb_pkg::KILL_CHAR_RESET;
         line_end_code  = leb_pkg::LINE_END_CHAR_RESET;
         overflow_flag  = 1'b0;
         mismatch_count = 0;
         line_q.delete();
         released_line_q.delete();
      end else begin
         // results first: nothing released at this edge can stem from an item taken now
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (released_line_q.size() == 0) begin
               $error("char_out: expected nothing, got %0d", rsp_ch.char_out);
               mismatch_count++;
            end else begin
               want = released_line_q.pop_front();
               check_field("char_out", int'(want.char_out), int'(rsp_ch.char_out));
               check_field("last_of_line", int'(want.last_of_line),
                           int'(rsp_ch.last_of_line));
               check_field("chars_dropped", int'(want.chars_dropped),
                           int'(rsp_ch.chars_dropped));
            end
         end
         if (csr_we) begin
            case (csr_index)
               leb_pkg::CSR_ERASE_CHAR:    erase_code    = csr_wdata;
               leb_pkg::CSR_KILL_CHAR:     kill_code     = csr_wdata;
               leb_pkg::CSR_LINE_END_CHAR: line_end_code = csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) edit_line(req_ch.op, req_ch.char_in);
      end
      pending_chars = released_line_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// testbench top: stimulus, idling, watchdog and verdict for the line edit buffer
`timescale 1ns / 1ps

module tb_top;

   localparam int LINE_DEPTH    = leb_pkg::LINE_DEPTH_DEFAULT;
   // drain of a release is one char per cycle while rsp_ch is ready; settle margin after the last char is out
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 8;
   // cycles with no item moving on either channel before the run is called hung
   localparam int STALL_LIMIT   = 4000;
   localparam int CHUNK_ITEMS   = 10;
   localparam int NUM_CHUNKS    = 6;
   // index with no register behind it, must be ignored
   localparam logic [1:0] CSR_UNUSED_INDEX = 2'd3;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;

   int check_failures;
   int pending_chars;
   int items_sent;
   int send_idle_pct;
   int recv_idle_pct;

   // register values currently loaded, used to steer the stimulus
   logic [7:0] erase_now;
   logic [7:0] kill_now;
   logic [7:0] line_end_now;

   // register settings per chunk: erase, kill, line end
   logic [7:0] erase_set    [NUM_CHUNKS] = '{8'd35, 8'h7F, 8'h00, 8'hFF, 8'h41, 8'd35};
   logic [7:0] kill_set     [NUM_CHUNKS] = '{8'd64, 8'h15, 8'hFF, 8'hFF, 8'h42, 8'd64};
   logic [7:0] line_end_set [NUM_CHUNKS] = '{8'd10, 8'h0D, 8'h00, 8'h0A, 8'h42, 8'd10};

   leb_req_if req_ch ();
   leb_rsp_if rsp_ch ();

   line_edit_buffer #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   leb_line_checker #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (check_failures),
      .pending_chars  (pending_chars)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // receiver side: ready decided fresh every falling edge
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog: a run with nothing moving for too long is hung
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("line_edit_buffer verification failed");
      $finish;
   end

   // ordinary char: matches none of the loaded control codes
   function automatic logic [7:0] pick_plain();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      while (c == erase_now || c == kill_now || c == line_end_now)
         c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // any code, with the control codes drawn far more often than chance
   function automatic logic [7:0] pick_any();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return erase_now;
      if (r < 20) return kill_now;
      if (r < 30) return line_end_now;
      return 8'($urandom_range(0, 255));
   endfunction

   // one item on the request channel; returns right after the edge that took it
   task automatic push_item(input logic op, input logic [7:0] ch);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.char_in <= ch;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // end of line: mostly the line-end char, otherwise a flush with junk in char_in
   task automatic end_line();
      if ($urandom_range(0, 99) < 70) push_item(leb_pkg::OP_CHAR, line_end_now);
      else push_item(leb_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
   endtask

   // stop sending and hold off until every released char has come out
   task automatic drain_and_wait(input int extra_cycles);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_chars != 0) @(negedge clock);
      repeat (extra_cycles) @(negedge clock);
   endtask

   // block is idle here; one register per cycle, optionally poking the unused index
   task automatic load_registers(input logic [7:0] e, input logic [7:0] k,
                                 input logic [7:0] l, input bit touch_unused);
      csr_we    <= 1'b1;
      csr_index <= leb_pkg::CSR_ERASE_CHAR;
      csr_wdata <= e;
      @(negedge clock);
      csr_index <= leb_pkg::CSR_KILL_CHAR;
      csr_wdata <= k;
      @(negedge clock);
      csr_index <= leb_pkg::CSR_LINE_END_CHAR;
      csr_wdata <= l;
      @(negedge clock);
      if (touch_unused) begin
         csr_index <= CSR_UNUSED_INDEX;
         csr_wdata <= 8'($urandom_range(0, 255));
         @(negedge clock);
      end
      csr_we       <= 1'b0;
      erase_now    =  e;
      kill_now     =  k;
      line_end_now =  l;
   endtask

   // fill to the depth or past it so chars may get dropped, then a tail that may erase or kill
   task automatic overflow_line();
      int fill;
      fill = LINE_DEPTH + $urandom_range(0, 3);
      repeat (fill) push_item(leb_pkg::OP_CHAR, pick_plain());
      case ($urandom_range(0, 2))
         0: push_item(leb_pkg::OP_CHAR, erase_now);       // flag must survive an erase
         1: begin
            push_item(leb_pkg::OP_CHAR, kill_now);        // kill starts a clean line
            repeat ($urandom_range(0, 3)) push_item(leb_pkg::OP_CHAR, pick_plain());
         end
         default: ;
      endcase
      end_line();
   endtask

   // one random sequence: mostly well-formed lines, some noise and odd corners
   task automatic random_sequence();
      int kind;
      int len;
      int r;
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
         len = $urandom_range(0, 10);
         repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 82) push_item(leb_pkg::OP_CHAR, pick_plain());
            else if (r < 93) push_item(leb_pkg::OP_CHAR, erase_now);
            else push_item(leb_pkg::OP_CHAR, kill_now);
         end
         end_line();
      end else if (kind < 85) begin
         len = $urandom_range(1, 6);
         repeat (len) begin
            if ($urandom_range(0, 9) == 0)
               push_item(leb_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
            else push_item(leb_pkg::OP_CHAR, pick_any());
         end
      end else begin
         // an erase, then back-to-back releases, the second one of an empty line
         push_item(leb_pkg::OP_CHAR, erase_now);
         push_item(leb_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
         end_line();
      end
   endtask

   initial begin
      int chunk_start;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = leb_pkg::CSR_ERASE_CHAR;
      csr_wdata      = 8'h00;
      req_ch.valid   = 1'b0;
      req_ch.op      = leb_pkg::OP_CHAR;
      req_ch.char_in = 8'h00;
      items_sent     = 0;
      send_idle_pct  = 28;
      recv_idle_pct  = 87;
      erase_now      = leb_pkg::ERASE_CHAR_RESET;
      kill_now       = leb_pkg::KILL_CHAR_RESET;
      line_end_now   = leb_pkg::LINE_END_CHAR_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed part at reset register values
      push_item(leb_pkg::OP_CHAR, 8'h00);                         // field extremes in one line
      push_item(leb_pkg::OP_CHAR, 8'hFF);
      push_item(leb_pkg::OP_CHAR, 8'h41);
      push_item(leb_pkg::OP_CHAR, leb_pkg::LINE_END_CHAR_RESET);
      push_item(leb_pkg::OP_CHAR, leb_pkg::LINE_END_CHAR_RESET);  // empty line releases nothing
      push_item(leb_pkg::OP_FLUSH, 8'hFF);                        // empty flush, char ignored
      push_item(leb_pkg::OP_CHAR, leb_pkg::ERASE_CHAR_RESET);     // erase with nothing buffered
      push_item(leb_pkg::OP_CHAR, 8'h61);
      push_item(leb_pkg::OP_CHAR, 8'h62);
      push_item(leb_pkg::OP_CHAR, leb_pkg::ERASE_CHAR_RESET);     // drops the newest char
      push_item(leb_pkg::OP_CHAR, 8'h63);
      push_item(leb_pkg::OP_FLUSH, leb_pkg::LINE_END_CHAR_RESET); // flush releases the line
      push_item(leb_pkg::OP_CHAR, 8'h78);
      push_item(leb_pkg::OP_CHAR, leb_pkg::KILL_CHAR_RESET);      // kill empties the line
      push_item(leb_pkg::OP_CHAR, 8'h79);
      push_item(leb_pkg::OP_CHAR, leb_pkg::LINE_END_CHAR_RESET);
      push_item(leb_pkg::OP_FLUSH, leb_pkg::ERASE_CHAR_RESET);    // flush of an already empty line
      push_item(leb_pkg::OP_CHAR, 8'h7A);
      push_item(leb_pkg::OP_FLUSH, 8'h00);
      push_item(leb_pkg::OP_FLUSH, leb_pkg::KILL_CHAR_RESET);     // repeated end of stream

      // random part: three idling phases, two register settings each
      for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
         case (chunk / 2)
            0: begin send_idle_pct = 28; recv_idle_pct = 87; end
            1: begin send_idle_pct = 87; recv_idle_pct = 28; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (chunk > 0) begin
            // registers only change with the block idle and nothing owed
            drain_and_wait(SETTLE_CYCLES);
            load_registers(erase_set[chunk[2:0]], kill_set[chunk[2:0]],
                           line_end_set[chunk[2:0]], chunk == NUM_CHUNKS - 1);
         end
         chunk_start = items_sent;
         // one line filled to the depth or beyond, under stalls
         if (chunk == 1) overflow_line();
         while (items_sent - chunk_start < CHUNK_ITEMS) random_sequence();
      end

      drain_and_wait(END_CYCLES);
      if (check_failures == 0) $display("line_edit_buffer verification clean");
      else $display("line_edit_buffer verification failed");
      $finish;
   end

endmodule
